@@ hw/rtl/lidar_point_colorizer_defines.svh @@
// ----------------------------------------------------------------------------
// Lidar point colorizer assertion macros
// Assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_COLORIZER_DEFINES_SVH
`define LIDAR_POINT_COLORIZER_DEFINES_SVH
`ifndef ASSERT_OFF
`define LPC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lidar_point_colorizer: assertion failed");
`define LPC_ASSERT_NEXT(label, clk, rst_n, cond, expct) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) \
        else $error("lidar_point_colorizer: assertion failed");
`else
`define LPC_ASSERT(label, clk, rst_n, prop)
`define LPC_ASSERT_NEXT(label, clk, rst_n, cond, expct)
`endif
`endif

@@ hw/rtl/lpc_pkg.sv @@
// ----------------------------------------------------------------------------
// Lidar point colorizer package
// Shared types, sizes and register codes of the colorizer.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 512;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int FRAME_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);

    localparam int PT_W   = 20;
    localparam int P_W    = 21;
    localparam int PR_W   = 37;
    localparam int CAM_W  = 37;
    localparam int LO_W   = 19;
    localparam int PPL_W  = 16 + LO_W;
    localparam int PPH_W  = 17 + CAM_W - LO_W;
    localparam int NUM_W  = 54;
    localparam int DEN_W  = CAM_W + 4;
    localparam int Q_W    = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
    localparam int DW     = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;
    localparam int LIM_W  = (Q_W > 11) ? Q_W : 11;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [2:0] {
        REG_ROT_X,
        REG_ROT_Y,
        REG_ROT_Z,
        REG_OFFSET,
        REG_FOCAL,
        REG_PRINCIPAL,
        REG_COLS,
        REG_ROWS
    } t_reg_idx;

    localparam logic [47:0] RST_ROT_X     = 48'h0000_0000_4000;
    localparam logic [47:0] RST_ROT_Y     = 48'h0000_4000_0000;
    localparam logic [47:0] RST_ROT_Z     = 48'h4000_0000_0000;
    localparam logic [47:0] RST_OFFSET    = 48'h0;
    localparam logic [31:0] RST_FOCAL     = 32'h1320_1320;
    localparam logic [31:0] RST_PRINCIPAL = 32'h0B7D_13D3;
    localparam logic [10:0] RST_COLS      = 11'd640;
    localparam logic [9:0]  RST_ROWS      = 10'd360;

    typedef struct packed {
        logic                action;
        logic signed [19:0]  point_x;
        logic signed [19:0]  point_y;
        logic signed [19:0]  point_z;
        logic [9:0]          pixel_col;
        logic [8:0]          pixel_row;
        logic [7:0]          pixel_red;
        logic [7:0]          pixel_green;
        logic [7:0]          pixel_blue;
    } t_in_item;

    typedef struct packed {
        logic signed [19:0]  colored_x;
        logic signed [19:0]  colored_y;
        logic signed [19:0]  colored_z;
        logic [7:0]          colored_red;
        logic [7:0]          colored_green;
        logic [7:0]          colored_blue;
        logic [9:0]          image_u;
        logic [8:0]          image_v;
    } t_out_item;

    typedef struct packed {
        logic                is_point;
        logic signed [19:0]  x;
        logic signed [19:0]  y;
        logic signed [19:0]  z;
        logic [9:0]          col;
        logic [8:0]          row;
        logic [23:0]         rgb;
    } t_side;

    typedef struct packed {
        logic [2:0][2:0][15:0] rot;
        logic [2:0][15:0]      offset;
        logic [15:0]           fx;
        logic [15:0]           fy;
        logic [15:0]           cx;
        logic [15:0]           cy;
        logic [10:0]           cols;
        logic [9:0]            rows;
    } t_cfg;

endpackage

@@ hw/rtl/lpc_cfg.sv @@
// ----------------------------------------------------------------------------
// Lidar point colorizer configuration registers
// APB register file holding the calibration and frame size.
// ----------------------------------------------------------------------------
module lpc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lpc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output lpc_pkg::t_cfg                     o_cfg
);

    logic [47:0] r_rot_x;
    logic [47:0] r_rot_y;
    logic [47:0] r_rot_z;
    logic [47:0] r_offset;
    logic [31:0] r_focal;
    logic [31:0] r_principal;
    logic [10:0] r_cols;
    logic [9:0]  r_rows;
    lpc_pkg::t_reg_idx w_idx;

    assign w_idx  = lpc_pkg::t_reg_idx'(paddr[lpc_pkg::CFG_ADDR_W-1:3]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x     <= lpc_pkg::RST_ROT_X;
            r_rot_y     <= lpc_pkg::RST_ROT_Y;
            r_rot_z     <= lpc_pkg::RST_ROT_Z;
            r_offset    <= lpc_pkg::RST_OFFSET;
            r_focal     <= lpc_pkg::RST_FOCAL;
            r_principal <= lpc_pkg::RST_PRINCIPAL;
            r_cols      <= lpc_pkg::RST_COLS;
            r_rows      <= lpc_pkg::RST_ROWS;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                lpc_pkg::REG_ROT_X:     r_rot_x     <= pwdata[47:0];
                lpc_pkg::REG_ROT_Y:     r_rot_y     <= pwdata[47:0];
                lpc_pkg::REG_ROT_Z:     r_rot_z     <= pwdata[47:0];
                lpc_pkg::REG_OFFSET:    r_offset    <= pwdata[47:0];
                lpc_pkg::REG_FOCAL:     r_focal     <= pwdata[31:0];
                lpc_pkg::REG_PRINCIPAL: r_principal <= pwdata[31:0];
                lpc_pkg::REG_COLS:      r_cols      <= pwdata[10:0];
                lpc_pkg::REG_ROWS:      r_rows      <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            lpc_pkg::REG_ROT_X:     prdata = lpc_pkg::CFG_DATA_W'(r_rot_x);
            lpc_pkg::REG_ROT_Y:     prdata = lpc_pkg::CFG_DATA_W'(r_rot_y);
            lpc_pkg::REG_ROT_Z:     prdata = lpc_pkg::CFG_DATA_W'(r_rot_z);
            lpc_pkg::REG_OFFSET:    prdata = lpc_pkg::CFG_DATA_W'(r_offset);
            lpc_pkg::REG_FOCAL:     prdata = lpc_pkg::CFG_DATA_W'(r_focal);
            lpc_pkg::REG_PRINCIPAL: prdata = lpc_pkg::CFG_DATA_W'(r_principal);
            lpc_pkg::REG_COLS:      prdata = lpc_pkg::CFG_DATA_W'(r_cols);
            lpc_pkg::REG_ROWS:      prdata = lpc_pkg::CFG_DATA_W'(r_rows);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg.rot[0] = r_rot_x;
    assign o_cfg.rot[1] = r_rot_y;
    assign o_cfg.rot[2] = r_rot_z;
    assign o_cfg.offset = r_offset;
    assign o_cfg.fx     = r_focal[15:0];
    assign o_cfg.fy     = r_focal[31:16];
    assign o_cfg.cx     = r_principal[15:0];
    assign o_cfg.cy     = r_principal[31:16];
    assign o_cfg.cols   = r_cols;
    assign o_cfg.rows   = r_rows;

endmodule

@@ hw/rtl/lpc_xform.sv @@
// ----------------------------------------------------------------------------
// Lidar point colorizer transform
// Offset, rotation and projection numerators in five register stages.
// ----------------------------------------------------------------------------
module lpc_xform (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  lpc_pkg::t_side                    i_side,
    input  lpc_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    output lpc_pkg::t_side                    o_side,
    output logic signed [lpc_pkg::NUM_W-1:0]  o_num_u,
    output logic signed [lpc_pkg::NUM_W-1:0]  o_num_v,
    output logic [lpc_pkg::DEN_W-1:0]         o_den
);

    logic [4:0] r_v;
    lpc_pkg::t_side r_side [5];

    logic signed [lpc_pkg::P_W-1:0]   r1_p [3];
    logic signed [lpc_pkg::PR_W-1:0]  r2_prod [3][3];
    logic signed [lpc_pkg::CAM_W-1:0] r3_cam [3];

    logic [lpc_pkg::PPL_W-1:0]         r4_uxl, r4_uzl, r4_vyl, r4_vzl;
    logic signed [lpc_pkg::PPH_W-1:0]  r4_uxh, r4_uzh, r4_vyh, r4_vzh;
    logic signed [lpc_pkg::CAM_W-1:0]  r4_zc;

    logic signed [lpc_pkg::NUM_W-1:0] r5_num_u, r5_num_v;
    logic [lpc_pkg::DEN_W-1:0]        r5_den;

    logic [lpc_pkg::LO_W-1:0]                  w_xl, w_yl, w_zl;
    logic signed [lpc_pkg::CAM_W-lpc_pkg::LO_W-1:0] w_xh, w_yh, w_zh;
    logic n_v4;

    assign w_xl = r3_cam[0][lpc_pkg::LO_W-1:0];
    assign w_yl = r3_cam[1][lpc_pkg::LO_W-1:0];
    assign w_zl = r3_cam[2][lpc_pkg::LO_W-1:0];
    assign w_xh = $signed(r3_cam[0][lpc_pkg::CAM_W-1:lpc_pkg::LO_W]);
    assign w_yh = $signed(r3_cam[1][lpc_pkg::CAM_W-1:lpc_pkg::LO_W]);
    assign w_zh = $signed(r3_cam[2][lpc_pkg::CAM_W-1:lpc_pkg::LO_W]);

    // Points on or behind the camera plane leave the pipeline here.
    assign n_v4 = r_v[2] && !(r_side[2].is_point && (r3_cam[2] <= lpc_pkg::CAM_W'(0)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[3], n_v4, r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= i_side;
            for (int s = 1; s < 5; s++) begin
                r_side[s] <= r_side[s-1];
            end

            r1_p[0] <= lpc_pkg::P_W'(i_side.x) + lpc_pkg::P_W'($signed(i_cfg.offset[0]));
            r1_p[1] <= lpc_pkg::P_W'(i_side.y) + lpc_pkg::P_W'($signed(i_cfg.offset[1]));
            r1_p[2] <= lpc_pkg::P_W'(i_side.z) + lpc_pkg::P_W'($signed(i_cfg.offset[2]));

            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r2_prod[r][c] <= lpc_pkg::PR_W'($signed(i_cfg.rot[r][c]))
                                   * lpc_pkg::PR_W'(r1_p[c]);
                end
            end

            for (int r = 0; r < 3; r++) begin
                r3_cam[r] <= lpc_pkg::CAM_W'(r2_prod[r][0]) + lpc_pkg::CAM_W'(r2_prod[r][1])
                           + lpc_pkg::CAM_W'(r2_prod[r][2]);
            end

            r4_uxl <= lpc_pkg::PPL_W'(i_cfg.fx) * lpc_pkg::PPL_W'(w_xl);
            r4_uzl <= lpc_pkg::PPL_W'(i_cfg.cx) * lpc_pkg::PPL_W'(w_zl);
            r4_vyl <= lpc_pkg::PPL_W'(i_cfg.fy) * lpc_pkg::PPL_W'(w_yl);
            r4_vzl <= lpc_pkg::PPL_W'(i_cfg.cy) * lpc_pkg::PPL_W'(w_zl);
            r4_uxh <= lpc_pkg::PPH_W'($signed({1'b0, i_cfg.fx})) * lpc_pkg::PPH_W'(w_xh);
            r4_uzh <= lpc_pkg::PPH_W'($signed({1'b0, i_cfg.cx})) * lpc_pkg::PPH_W'(w_zh);
            r4_vyh <= lpc_pkg::PPH_W'($signed({1'b0, i_cfg.fy})) * lpc_pkg::PPH_W'(w_yh);
            r4_vzh <= lpc_pkg::PPH_W'($signed({1'b0, i_cfg.cy})) * lpc_pkg::PPH_W'(w_zh);
            r4_zc  <= r3_cam[2];

            r5_num_u <= ((lpc_pkg::NUM_W'(r4_uxh) + lpc_pkg::NUM_W'(r4_uzh)) << lpc_pkg::LO_W)
                      + lpc_pkg::NUM_W'(r4_uxl) + lpc_pkg::NUM_W'(r4_uzl);
            r5_num_v <= ((lpc_pkg::NUM_W'(r4_vyh) + lpc_pkg::NUM_W'(r4_vzh)) << lpc_pkg::LO_W)
                      + lpc_pkg::NUM_W'(r4_vyl) + lpc_pkg::NUM_W'(r4_vzl);
            r5_den   <= lpc_pkg::DEN_W'(r4_zc) << 4;
        end
    end

    assign o_valid = r_v[4];
    assign o_side  = r_side[4];
    assign o_num_u = r5_num_u;
    assign o_num_v = r5_num_v;
    assign o_den   = r5_den;

endmodule

@@ hw/rtl/lpc_div.sv @@
// ----------------------------------------------------------------------------
// Lidar point colorizer divider
// Pipelined restoring divider, one quotient bit per stage for u and v.
// ----------------------------------------------------------------------------
module lpc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  lpc_pkg::t_side                    i_side,
    input  logic signed [lpc_pkg::NUM_W-1:0]  i_num_u,
    input  logic signed [lpc_pkg::NUM_W-1:0]  i_num_v,
    input  logic [lpc_pkg::DEN_W-1:0]         i_den,
    output logic                              o_valid,
    output lpc_pkg::t_side                    o_side,
    output logic [lpc_pkg::Q_W-1:0]           o_q_u,
    output logic [lpc_pkg::Q_W-1:0]           o_q_v
);

    localparam int DW  = lpc_pkg::DW;
    localparam int Q_W = lpc_pkg::Q_W;

    logic                        r_p_v;
    lpc_pkg::t_side              r_p_side;
    logic                        r_p_neg_u, r_p_neg_v;
    logic [lpc_pkg::NUM_W-1:0]   r_p_mag_u, r_p_mag_v;
    logic [lpc_pkg::DEN_W-1:0]   r_p_den;

    logic [Q_W:0]                r_v;
    lpc_pkg::t_side              r_side [Q_W+1];
    logic [DW-1:0]               r_rem_u [Q_W];
    logic [DW-1:0]               r_rem_v [Q_W];
    logic [Q_W-1:0]              r_q_u [Q_W+1];
    logic [Q_W-1:0]              r_q_v [Q_W+1];
    logic [lpc_pkg::DEN_W-1:0]   r_den [Q_W];

    logic [DW-1:0] w_den, w_a_u, w_a_v, w_lim;
    logic          w_drop;

    assign w_den = DW'(r_p_den);
    assign w_lim = w_den << Q_W;
    assign w_a_u = r_p_neg_u ? '0 : DW'(r_p_mag_u);
    assign w_a_v = r_p_neg_v ? '0 : DW'(r_p_mag_v);

    // A negative quotient of magnitude one or more, or a quotient too wide for
    // the quotient register, can never land inside the image.
    assign w_drop = (r_p_neg_u && (DW'(r_p_mag_u) >= w_den))
                 || (r_p_neg_v && (DW'(r_p_mag_v) >= w_den))
                 || (w_a_u >= w_lim) || (w_a_v >= w_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v  <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_p_v  <= i_valid;
            r_v[0] <= r_p_v && !(r_p_side.is_point && w_drop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p_side  <= i_side;
            r_p_neg_u <= i_num_u[lpc_pkg::NUM_W-1];
            r_p_neg_v <= i_num_v[lpc_pkg::NUM_W-1];
            r_p_mag_u <= i_num_u[lpc_pkg::NUM_W-1] ? -i_num_u : i_num_u;
            r_p_mag_v <= i_num_v[lpc_pkg::NUM_W-1] ? -i_num_v : i_num_v;
            r_p_den   <= i_den;

            r_side[0]  <= r_p_side;
            r_rem_u[0] <= w_a_u;
            r_rem_v[0] <= w_a_v;
            r_q_u[0]   <= '0;
            r_q_v[0]   <= '0;
            r_den[0]   <= r_p_den;
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
        logic [DW-1:0] w_sh;
        logic          w_ge_u, w_ge_v;

        assign w_sh   = DW'(r_den[k-1]) << (Q_W - k);
        assign w_ge_u = r_rem_u[k-1] >= w_sh;
        assign w_ge_v = r_rem_v[k-1] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[k]  <= r_side[k-1];
                r_q_u[k]   <= {r_q_u[k-1][Q_W-2:0], w_ge_u};
                r_q_v[k]   <= {r_q_v[k-1][Q_W-2:0], w_ge_v};
            end
        end

        if (k < Q_W) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_den[k]   <= r_den[k-1];
                    r_rem_u[k] <= w_ge_u ? (r_rem_u[k-1] - w_sh) : r_rem_u[k-1];
                    r_rem_v[k] <= w_ge_v ? (r_rem_v[k-1] - w_sh) : r_rem_v[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_side  = r_side[Q_W];
    assign o_q_u   = r_q_u[Q_W];
    assign o_q_v   = r_q_v[Q_W];

endmodule

@@ hw/rtl/lpc_lookup.sv @@
// ----------------------------------------------------------------------------
// Lidar point colorizer frame lookup
// Frame store, bounds check and the output register.
// ----------------------------------------------------------------------------
module lpc_lookup (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  lpc_pkg::t_side               i_side,
    input  logic [lpc_pkg::Q_W-1:0]      i_q_u,
    input  logic [lpc_pkg::Q_W-1:0]      i_q_v,
    input  lpc_pkg::t_cfg                i_cfg,
    output logic                         o_valid,
    output lpc_pkg::t_out_item           o_data
);

    localparam int LIM_W  = lpc_pkg::LIM_W;
    localparam int ADDR_W = lpc_pkg::ADDR_W;

    logic [23:0]             r_frame [lpc_pkg::FRAME_DEPTH];
    logic                    r_loaded;
    logic                    r_ov;
    logic [23:0]             r_rd;
    lpc_pkg::t_side          r_side;
    logic [9:0]              r_u;
    logic [8:0]              r_v;

    logic [LIM_W-1:0]  w_cols, w_rows, w_u, w_v;
    logic              w_hit, w_store;
    logic [ADDR_W-1:0] w_rd_addr, w_wr_addr, w_addr;

    assign w_cols = (LIM_W'(i_cfg.cols) < LIM_W'(lpc_pkg::MAX_COLS))
                  ? LIM_W'(i_cfg.cols) : LIM_W'(lpc_pkg::MAX_COLS);
    assign w_rows = (LIM_W'(i_cfg.rows) < LIM_W'(lpc_pkg::MAX_ROWS))
                  ? LIM_W'(i_cfg.rows) : LIM_W'(lpc_pkg::MAX_ROWS);
    assign w_u    = LIM_W'(i_q_u);
    assign w_v    = LIM_W'(i_q_v);

    assign w_hit   = i_side.is_point && r_loaded && (w_u < w_cols) && (w_v < w_rows);
    assign w_store = !i_side.is_point
                  && (32'(i_side.col) < 32'(lpc_pkg::MAX_COLS))
                  && (32'(i_side.row) < 32'(lpc_pkg::MAX_ROWS));

    assign w_rd_addr = ADDR_W'(ADDR_W'(i_q_v) * ADDR_W'(lpc_pkg::MAX_COLS) + ADDR_W'(i_q_u));
    assign w_wr_addr = ADDR_W'(ADDR_W'(i_side.row) * ADDR_W'(lpc_pkg::MAX_COLS)
                     + ADDR_W'(i_side.col));
    assign w_addr    = i_side.is_point ? w_rd_addr : w_wr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_ov     <= 1'b0;
        end else if (i_adv) begin
            r_ov <= i_valid && w_hit;
            if (i_valid && !i_side.is_point) begin
                r_loaded <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_valid && w_store) begin
                r_frame[w_addr] <= i_side.rgb;
            end
            r_rd   <= r_frame[w_addr];
            r_side <= i_side;
            r_u    <= i_q_u[9:0];
            r_v    <= i_q_v[8:0];
        end
    end

    assign o_valid              = r_ov;
    assign o_data.colored_x     = r_side.x;
    assign o_data.colored_y     = r_side.y;
    assign o_data.colored_z     = r_side.z;
    assign o_data.colored_red   = r_rd[23:16];
    assign o_data.colored_green = r_rd[15:8];
    assign o_data.colored_blue  = r_rd[7:0];
    assign o_data.image_u       = r_u;
    assign o_data.image_v       = r_v;

endmodule

@@ hw/rtl/lidar_point_colorizer.sv @@
// ----------------------------------------------------------------------------
// Lidar point colorizer
// Projects lidar points into a stored camera frame and returns their color.
//
// Input channel: one item per transfer, either a pixel write (action 0) that
// stores an RGB value, or a lidar point (action 1). Output channel: one
// transfer per point that projects inside the frame; all other items give
// no output. Calibration and frame size are set through the APB port.
// From input transfer to output valid an item passes five stages of
// offset, rotation and numerator math, two divider setup stages, one
// divider stage per quotient bit (eleven) and the frame lookup register.
// Throughput is one item per cycle while the output is not stalled; every
// stage register and the frame store port advance together.
// At reset the pipeline empties, the registers take the identity pose and
// the default camera, and points are dropped until a pixel is written.
// When the receiver stalls a valid output, the whole pipeline holds and the
// input channel stalls in the same cycle.
// ----------------------------------------------------------------------------
`include "lidar_point_colorizer_defines.svh"

module lidar_point_colorizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  lpc_pkg::t_in_item                 i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output lpc_pkg::t_out_item                o_out_data,
    input  logic                              i_out_stall,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lpc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lpc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    lpc_pkg::t_cfg   w_cfg;
    lpc_pkg::t_side  w_in_side;
    logic            w_adv;

    logic                              w_x_valid;
    lpc_pkg::t_side                    w_x_side;
    logic signed [lpc_pkg::NUM_W-1:0]  w_num_u, w_num_v;
    logic [lpc_pkg::DEN_W-1:0]         w_den;

    logic                              w_d_valid;
    lpc_pkg::t_side                    w_d_side;
    logic [lpc_pkg::Q_W-1:0]           w_q_u, w_q_v;

    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;

    assign w_in_side.is_point = i_in_data.action;
    assign w_in_side.x        = i_in_data.point_x;
    assign w_in_side.y        = i_in_data.point_y;
    assign w_in_side.z        = i_in_data.point_z;
    assign w_in_side.col      = i_in_data.pixel_col;
    assign w_in_side.row      = i_in_data.pixel_row;
    assign w_in_side.rgb      = {i_in_data.pixel_red, i_in_data.pixel_green,
                                 i_in_data.pixel_blue};

    lpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lpc_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in_valid),
        .i_side  (w_in_side),
        .i_cfg   (w_cfg),
        .o_valid (w_x_valid),
        .o_side  (w_x_side),
        .o_num_u (w_num_u),
        .o_num_v (w_num_v),
        .o_den   (w_den)
    );

    lpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_x_valid),
        .i_side  (w_x_side),
        .i_num_u (w_num_u),
        .i_num_v (w_num_v),
        .i_den   (w_den),
        .o_valid (w_d_valid),
        .o_side  (w_d_side),
        .o_q_u   (w_q_u),
        .o_q_v   (w_q_v)
    );

    lpc_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_d_valid),
        .i_side  (w_d_side),
        .i_q_u   (w_q_u),
        .i_q_v   (w_q_v),
        .i_cfg   (w_cfg),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    `LPC_ASSERT(a_idle_no_stall, i_clk, i_rst_n, !o_out_valid |-> !o_in_stall)
    `LPC_ASSERT(a_out_after_advance, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(!o_in_stall))
    `LPC_ASSERT_NEXT(a_hold_keeps_out, i_clk, i_rst_n, o_in_stall, o_out_valid)

endmodule
